>>> hw/rtl/tle_pkg.sv
// Shared package for the terminal line editor.
// Holds the sizes, character codes, edit operation codes and the command and
// status structs between the controller and the datapath. No dependencies.
package tle_pkg;

  localparam int unsigned LineCapacity = 16;
  localparam int unsigned IdxW         = $clog2(LineCapacity);
  localparam int unsigned CntW         = $clog2(LineCapacity + 1);
  localparam int unsigned CharW        = 8;
  localparam int unsigned StoreW       = 7;
  localparam int unsigned LimitW       = 5;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(16);

  localparam logic [CharW-1:0] CH_BS     = 8'h08;
  localparam logic [CharW-1:0] CH_NL     = 8'h0A;
  localparam logic [CharW-1:0] CH_ESC    = 8'h1B;
  localparam logic [CharW-1:0] CH_SPACE  = 8'h20;
  localparam logic [CharW-1:0] CH_THREE  = 8'h33;
  localparam logic [CharW-1:0] CH_UPC    = 8'h43;
  localparam logic [CharW-1:0] CH_UPD    = 8'h44;
  localparam logic [CharW-1:0] CH_UPF    = 8'h46;
  localparam logic [CharW-1:0] CH_UPH    = 8'h48;
  localparam logic [CharW-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CharW-1:0] CH_TILDE  = 8'h7E;
  localparam logic [CharW-1:0] CH_DEL    = 8'h7F;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_INSERT  = 4'd1,
    OP_BKSP    = 4'd2,
    OP_DELETE  = 4'd3,
    OP_LEFT    = 4'd4,
    OP_RIGHT   = 4'd5,
    OP_HOME    = 4'd6,
    OP_END     = 4'd7,
    OP_NEWLINE = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    SEL_HEAD  = 3'd0,
    SEL_TAIL  = 3'd1,
    SEL_BLANK = 3'd2,
    SEL_BACK  = 3'd3,
    SEL_CLOSE = 3'd4
  } sel_e;

  typedef struct packed {
    logic             load;
    op_e              op;
    logic [CharW-1:0] in_char;
    logic             emit;
    sel_e             sel;
    logic             last;
    logic             tail_step;
    logic             back_step;
  } cmd_t;

  typedef struct packed {
    logic cur_zero;
    logic at_end;
    logic full;
    logic tail_empty;
    logic tail_one;
    logic back_zero;
    logic back_one;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/terminal_line_editor.sv
// Terminal line editor: one received byte per transaction in, echo and line bytes out.
// A byte with no echo gives no result; a byte gives at most 33 results, and the next byte
// is not accepted until the last result of the current one has been emitted.
// Throughput is bounded by the single output register, fed one character per cycle while it is free.
// Reset (rst_ni, async, active low): line empty, cursor 0, normal mode, limit 16;
// the line store is not cleared. Depends on tle_pkg, tle_ctrl, tle_dp.
module terminal_line_editor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: line_limit
  input  logic                          cfg_we_i,
  input  logic [tle_pkg::LimitW-1:0]    cfg_wdata_i,
  // received characters
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tle_pkg::CharW-1:0]     in_char_i,
  // echo and finished line bytes
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [tle_pkg::CharW-1:0]     out_char_o,
  output logic                          last_o
);

  tle_pkg::cmd_t cmd;
  tle_pkg::sts_t sts;

  // Controller: decodes the byte (with the escape state), picks the edit and then
  // walks the echo phases (head char, redrawn tail, blank, backspaces, closing newline).
  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_char_i  (in_char_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: shifts the line store on the accepting edge, keeps cursor and length,
  // counts the tail and backspace runs and holds the output register.
  tle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_kind_o  (out_kind_o),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

  // A character is only pushed into a free output slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit |-> sts.out_free)
    else $error("emit into occupied output register");

  // When waiting for input, no echo run is left pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (sts.tail_empty && sts.back_zero))
    else $error("idle with pending echo run");

  // The final result of a transaction returns the controller to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last) |=> in_ready_o)
    else $error("not idle after last result");

  // Emitting a result marks the output valid on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit |=> out_valid_o)
    else $error("emitted result not presented");

endmodule

>>> hw/rtl/tle_dp.sv
// Datapath of the terminal line editor: line store, cursor, length, limit,
// echo walk counters and the output register. Depends on tle_pkg.
module tle_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tle_pkg::LimitW-1:0]         cfg_wdata_i,
  input  tle_pkg::cmd_t                      cmd_i,
  output tle_pkg::sts_t                      sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_kind_o,
  output logic [tle_pkg::CharW-1:0]          out_char_o,
  output logic                               last_o
);

  logic [tle_pkg::StoreW-1:0] store_q [tle_pkg::LineCapacity];
  logic [tle_pkg::StoreW-1:0] store_d [tle_pkg::LineCapacity];

  logic [tle_pkg::LimitW-1:0] limit_q;
  logic [tle_pkg::CntW-1:0]   cursor_q, cursor_d;
  logic [tle_pkg::CntW-1:0]   len_q, len_d;
  logic [tle_pkg::CntW-1:0]   idx_q, idx_d;
  logic [tle_pkg::CntW-1:0]   end_q, end_d;
  logic [tle_pkg::CntW-1:0]   back_q, back_d;
  logic [tle_pkg::CharW-1:0]  hd_q, hd_d;
  logic                       tkind_q, tkind_d;

  logic                       out_valid_q;
  logic                       out_kind_q;
  logic [tle_pkg::CharW-1:0]  out_char_q;
  logic                       out_last_q;
  logic                       emit_kind;
  logic [tle_pkg::CharW-1:0]  emit_char;

  logic [tle_pkg::CntW-1:0]   lim;
  logic [tle_pkg::CntW-1:0]   cur_m1;
  logic [tle_pkg::CntW-1:0]   len_m1;
  logic [tle_pkg::CntW-1:0]   rm_at;
  logic [tle_pkg::CntW-1:0]   nl_end;
  logic [tle_pkg::StoreW-1:0] rd_char;

  // effective limit: values above capacity act as capacity
  assign lim = (tle_pkg::CntW'(limit_q) > tle_pkg::CntW'(tle_pkg::LineCapacity))
             ? tle_pkg::CntW'(tle_pkg::LineCapacity) : tle_pkg::CntW'(limit_q);
  assign cur_m1 = cursor_q - tle_pkg::CntW'(1);
  assign len_m1 = len_q - tle_pkg::CntW'(1);
  assign rm_at  = (cmd_i.op == tle_pkg::OP_BKSP) ? cur_m1 : cursor_q;
  assign nl_end = (len_q > tle_pkg::CntW'(tle_pkg::LineCapacity - 1))
                ? tle_pkg::CntW'(tle_pkg::LineCapacity - 1) : len_q;
  assign rd_char = store_q[idx_q[tle_pkg::IdxW-1:0]];

  // store shifting for insert and removal
  always_comb begin
    for (int i = 0; i < tle_pkg::LineCapacity; i++) begin
      store_d[i] = store_q[i];
    end
    if (cmd_i.load && cmd_i.op == tle_pkg::OP_INSERT) begin
      for (int i = 1; i < tle_pkg::LineCapacity; i++) begin
        if (tle_pkg::CntW'(i) > cursor_q && tle_pkg::CntW'(i) <= len_q) begin
          store_d[i] = store_q[i-1];
        end
      end
      for (int i = 0; i < tle_pkg::LineCapacity; i++) begin
        if (tle_pkg::CntW'(i) == cursor_q) begin
          store_d[i] = cmd_i.in_char[tle_pkg::StoreW-1:0];
        end
      end
    end else if (cmd_i.load && (cmd_i.op == tle_pkg::OP_BKSP ||
                                cmd_i.op == tle_pkg::OP_DELETE)) begin
      for (int i = 0; i < tle_pkg::LineCapacity - 1; i++) begin
        if (tle_pkg::CntW'(i) >= rm_at && tle_pkg::CntW'(i + 1) < len_q) begin
          store_d[i] = store_q[i+1];
        end
      end
    end
  end

  // edit and echo plan
  always_comb begin
    cursor_d = cursor_q;
    len_d    = len_q;
    idx_d    = idx_q;
    end_d    = end_q;
    back_d   = back_q;
    hd_d     = hd_q;
    tkind_d  = tkind_q;
    if (cmd_i.load) begin
      idx_d   = '0;
      end_d   = '0;
      back_d  = '0;
      hd_d    = tle_pkg::CH_BS;
      tkind_d = 1'b0;
      unique case (cmd_i.op)
        tle_pkg::OP_INSERT: begin
          cursor_d = cursor_q + tle_pkg::CntW'(1);
          len_d    = len_q + tle_pkg::CntW'(1);
          idx_d    = cursor_q + tle_pkg::CntW'(1);
          end_d    = len_q + tle_pkg::CntW'(1);
          back_d   = len_q - cursor_q;
          hd_d     = cmd_i.in_char;
        end
        tle_pkg::OP_BKSP: begin
          cursor_d = cur_m1;
          len_d    = len_m1;
          idx_d    = cur_m1;
          end_d    = len_m1;
          back_d   = len_q - cursor_q + tle_pkg::CntW'(1);
        end
        tle_pkg::OP_DELETE: begin
          len_d  = len_m1;
          idx_d  = cursor_q;
          end_d  = len_m1;
          back_d = len_q - cursor_q;
        end
        tle_pkg::OP_LEFT: begin
          cursor_d = cur_m1;
        end
        tle_pkg::OP_RIGHT: begin
          cursor_d = cursor_q + tle_pkg::CntW'(1);
          idx_d    = cursor_q;
          end_d    = cursor_q + tle_pkg::CntW'(1);
        end
        tle_pkg::OP_HOME: begin
          cursor_d = '0;
          back_d   = cursor_q;
        end
        tle_pkg::OP_END: begin
          cursor_d = len_q;
          idx_d    = cursor_q;
          end_d    = len_q;
        end
        tle_pkg::OP_NEWLINE: begin
          cursor_d = '0;
          len_d    = '0;
          end_d    = nl_end;
          hd_d     = tle_pkg::CH_NL;
          tkind_d  = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      if (cmd_i.tail_step) idx_d = idx_q + tle_pkg::CntW'(1);
      if (cmd_i.back_step) back_d = back_q - tle_pkg::CntW'(1);
    end
  end

  always_comb begin
    emit_kind = 1'b0;
    emit_char = tle_pkg::CH_BS;
    unique case (cmd_i.sel)
      tle_pkg::SEL_HEAD:  emit_char = hd_q;
      tle_pkg::SEL_TAIL: begin
        emit_kind = tkind_q;
        emit_char = {1'b0, rd_char};
      end
      tle_pkg::SEL_BLANK: emit_char = tle_pkg::CH_SPACE;
      tle_pkg::SEL_BACK:  emit_char = tle_pkg::CH_BS;
      tle_pkg::SEL_CLOSE: begin
        emit_kind = 1'b1;
        emit_char = tle_pkg::CH_NL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= tle_pkg::LimitReset;
      cursor_q    <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      end_q       <= '0;
      back_q      <= '0;
      tkind_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      cursor_q <= cursor_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      end_q    <= end_d;
      back_q   <= back_d;
      tkind_q  <= tkind_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < tle_pkg::LineCapacity; i++) begin
      store_q[i] <= store_d[i];
    end
    hd_q <= hd_d;
    if (cmd_i.emit) begin
      out_kind_q <= emit_kind;
      out_char_q <= emit_char;
      out_last_q <= cmd_i.last;
    end
  end

  // fields in struct order: cur_zero, at_end, full, tail_empty, tail_one,
  // back_zero, back_one, out_free
  assign sts_o = {(cursor_q == '0),
                  (cursor_q == len_q),
                  (len_q >= lim),
                  (idx_q == end_q),
                  ((idx_q + tle_pkg::CntW'(1)) == end_q),
                  (back_q == '0),
                  (back_q == tle_pkg::CntW'(1)),
                  (!out_valid_q || out_ready_i)};

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

endmodule

>>> hw/rtl/tle_ctrl.sv
// Controller of the terminal line editor: escape decoding, edit selection
// and the echo phase sequencer. Depends on tle_pkg.
module tle_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [tle_pkg::CharW-1:0] in_char_i,
  input  tle_pkg::sts_t             sts_i,
  output tle_pkg::cmd_t             cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_HEAD  = 7'b0000100,
    S_TAIL  = 7'b0001000,
    S_BLANK = 7'b0010000,
    S_BACK  = 7'b0100000,
    S_CLOSE = 7'b1000000
  } state_e;

  typedef enum logic [3:0] {
    M_NORMAL = 4'b0001,
    M_ESC1   = 4'b0010,
    M_ESC2   = 4'b0100,
    M_ESC3   = 4'b1000
  } mode_e;

  state_e state_q, state_d;
  state_e after_head, after_tail, after_blank, after_back, nxt;
  mode_e  mode_q, mode_d;
  logic   head_en_q, head_en_d;
  logic   blank_en_q, blank_en_d;
  logic   close_en_q, close_en_d;
  logic   accept;
  logic   printable;
  logic   emit;
  tle_pkg::sel_e sel;
  tle_pkg::op_e op;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign printable  = (in_char_i >= tle_pkg::CH_SPACE) && (in_char_i < tle_pkg::CH_DEL);

  // decode the received byte against the escape mode
  always_comb begin
    op     = tle_pkg::OP_NONE;
    mode_d = mode_q;
    unique case (mode_q)
      M_NORMAL: begin
        if (in_char_i == tle_pkg::CH_NL) begin
          op = tle_pkg::OP_NEWLINE;
        end else if (in_char_i == tle_pkg::CH_ESC) begin
          mode_d = M_ESC1;
        end else if (in_char_i == tle_pkg::CH_DEL || in_char_i == tle_pkg::CH_BS) begin
          if (!sts_i.cur_zero) op = tle_pkg::OP_BKSP;
        end else if (printable && !sts_i.full) begin
          op = tle_pkg::OP_INSERT;
        end
      end
      M_ESC1: begin
        mode_d = (in_char_i == tle_pkg::CH_LBRACK) ? M_ESC2 : M_NORMAL;
      end
      M_ESC2: begin
        mode_d = M_NORMAL;
        if (in_char_i == tle_pkg::CH_UPD) begin
          if (!sts_i.cur_zero) op = tle_pkg::OP_LEFT;
        end else if (in_char_i == tle_pkg::CH_UPC) begin
          if (!sts_i.at_end) op = tle_pkg::OP_RIGHT;
        end else if (in_char_i == tle_pkg::CH_UPH) begin
          op = tle_pkg::OP_HOME;
        end else if (in_char_i == tle_pkg::CH_UPF) begin
          op = tle_pkg::OP_END;
        end else if (in_char_i == tle_pkg::CH_THREE) begin
          mode_d = M_ESC3;
        end
      end
      M_ESC3: begin
        mode_d = M_NORMAL;
        if (in_char_i == tle_pkg::CH_TILDE && !sts_i.at_end) op = tle_pkg::OP_DELETE;
      end
      default: mode_d = M_NORMAL;
    endcase
  end

  // phase order: head, tail, blank, back, close
  assign after_back  = close_en_q ? S_CLOSE : S_IDLE;
  assign after_blank = !sts_i.back_zero ? S_BACK : after_back;
  assign after_tail  = blank_en_q ? S_BLANK : after_blank;
  assign after_head  = !sts_i.tail_empty ? S_TAIL : after_tail;

  always_comb begin
    nxt = S_IDLE;
    sel = tle_pkg::SEL_HEAD;
    unique case (state_q)
      S_HEAD:  nxt = after_head;
      S_TAIL: begin
        nxt = sts_i.tail_one ? after_tail : S_TAIL;
        sel = tle_pkg::SEL_TAIL;
      end
      S_BLANK: begin
        nxt = after_blank;
        sel = tle_pkg::SEL_BLANK;
      end
      S_BACK: begin
        nxt = sts_i.back_one ? after_back : S_BACK;
        sel = tle_pkg::SEL_BACK;
      end
      S_CLOSE: begin
        nxt = S_IDLE;
        sel = tle_pkg::SEL_CLOSE;
      end
      default: nxt = S_IDLE;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    head_en_d  = head_en_q;
    blank_en_d = blank_en_q;
    close_en_d = close_en_q;
    emit       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d    = S_START;
          head_en_d  = (op == tle_pkg::OP_INSERT) || (op == tle_pkg::OP_BKSP) ||
                       (op == tle_pkg::OP_LEFT) || (op == tle_pkg::OP_NEWLINE);
          blank_en_d = (op == tle_pkg::OP_BKSP) || (op == tle_pkg::OP_DELETE);
          close_en_d = (op == tle_pkg::OP_NEWLINE);
        end
      end
      S_START: state_d = head_en_q ? S_HEAD : after_head;
      S_HEAD, S_TAIL, S_BLANK, S_BACK, S_CLOSE: begin
        if (sts_i.out_free) begin
          emit    = 1'b1;
          state_d = nxt;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // fields in struct order: load, op, in_char, emit, sel, last, tail_step, back_step
  assign cmd_o = {accept, op, in_char_i, emit, sel, (nxt == S_IDLE),
                  emit && (state_q == S_TAIL), emit && (state_q == S_BACK)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= M_NORMAL;
      head_en_q  <= 1'b0;
      blank_en_q <= 1'b0;
      close_en_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (accept) mode_q <= mode_d;
      head_en_q  <= head_en_d;
      blank_en_q <= blank_en_d;
      close_en_q <= close_en_d;
    end
  end

endmodule
